FILE: rtl/core/wwg_pkg.sv
// Package for the Wireworld generation engine: cell and request codes, sizes, next-state rule.
`timescale 1ns / 1ps
package wwg_pkg;

   localparam int GRID_SIZE_DEF = 64;

   // request word layout
   localparam int ROW_W   = 6;
   localparam int COL_W   = 6;
   localparam int CELL_W  = 2;
   localparam int REQ_W   = 2;
   localparam int REQ_DW  = 16;
   localparam int RSP_DW  = 8;

   localparam logic [CELL_W-1:0] CELL_EMPTY = 2'd0;
   localparam logic [CELL_W-1:0] CELL_HEAD  = 2'd1;
   localparam logic [CELL_W-1:0] CELL_TAIL  = 2'd2;
   localparam logic [CELL_W-1:0] CELL_COND  = 2'd3;

   localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
   localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_STEP  = 2'd2;

   // head count saturates at 3; only 1 and 2 matter
   function automatic logic [1:0] heads_add(input logic [1:0] heads, input logic hit);
      logic [1:0] res;
      res = heads;
      if (hit && heads != 2'd3) begin
         res = heads + 2'd1;
      end
      return res;
   endfunction

   function automatic logic [CELL_W-1:0] cell_evolve(input logic [CELL_W-1:0] cur,
                                                     input logic [1:0] heads);
      logic [CELL_W-1:0] res;
      case (cur)
         CELL_EMPTY: res = CELL_EMPTY;
         CELL_HEAD:  res = CELL_TAIL;
         CELL_TAIL:  res = CELL_COND;
         CELL_COND:  res = (heads == 2'd1 || heads == 2'd2) ? CELL_HEAD : CELL_COND;
         default:    res = CELL_EMPTY;
      endcase
      return res;
   endfunction

endpackage

FILE: rtl/core/wireworld_generation_engine.sv
// Wireworld grid store with cell read/write and a sequenced one-generation step.
//
// Usage:
//   req_* stream carries one request per word. req_tuser is the request kind
//   (write cell, read cell, advance one generation); req_tdata holds row, col
//   and the cell to write. Every request gives exactly one word on rsp_*:
//   the cell read back (zero for writes and steps) and a done flag.
//   A write answers in the cycle after acceptance; a read passes the registered
//   grid word to the response register through ST_RD_WAIT. A write may be
//   accepted every cycle while the response register is free or being drained;
//   a read holds off the next request while it waits in ST_RD_WAIT. A generation
//   step walks the grid one cell at a time, reading the nine cells of its
//   neighbourhood through the live bank's read port, one per cycle, in ST_STEP_RD,
//   then writing the new cell in ST_STEP_FIN; after the last cell it answers.
//   Two grid banks alternate; a step writes the new generation into the
//   other bank and then swaps them.
//   After reset a clearing pass empties all 2**(2*clog2(GRID_SIZE)) cells of
//   the live bank (4096 at 64x64), one cell per cycle; req_tready stays low.
//   When rsp_tready is low the response holds and no new request is taken.
`timescale 1ns / 1ps
module wireworld_generation_engine #(
   parameter int GRID_SIZE = wwg_pkg::GRID_SIZE_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [wwg_pkg::REQ_W-1:0]  req_tuser,   // req_type[1:0]
   input  logic [wwg_pkg::REQ_DW-1:0] req_tdata,   // row[5:0], col[11:6], cell_in[13:12], zero
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [wwg_pkg::RSP_DW-1:0] rsp_tdata    // cell_out[1:0], done_res[2], zero
);
   import wwg_pkg::*;

   localparam int RW    = $clog2(GRID_SIZE);
   localparam int AW    = 2 * RW;
   localparam int DEPTH = 1 << AW;
   localparam int CMPW  = ((RW > ROW_W) ? RW : ROW_W) + 1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_WAIT,
      ST_STEP_RD,
      ST_STEP_FIN
   } state_type;

   state_type          state_ff, state_in;
   logic               cur_ff, cur_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [RW-1:0]      cell_r_ff, cell_r_in, cell_c_ff, cell_c_in;
   logic [1:0]         dr_ff, dr_in, dc_ff, dc_in;
   logic               pend_ff, pend_in, pend_oor_ff, pend_oor_in, pend_ctr_ff, pend_ctr_in;
   logic [1:0]         heads_ff, heads_in;
   logic [CELL_W-1:0]  center_ff, center_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]  rsp_cell_ff, rsp_cell_in;

   logic [CELL_W-1:0]  mem0 [DEPTH];
   logic [CELL_W-1:0]  mem1 [DEPTH];
   logic [CELL_W-1:0]  rd0_ff, rd1_ff;
   logic [CELL_W-1:0]  rd_cell;

   logic [AW-1:0]      rd_addr, wr_addr;
   logic               wr_en, wr_bank;
   logic [CELL_W-1:0]  wr_data;

   logic [REQ_W-1:0]   req_type;
   logic [ROW_W-1:0]   row;
   logic [COL_W-1:0]   col;
   logic [CELL_W-1:0]  cell_in;
   logic               in_grid;
   logic [RW-1:0]      req_r, req_c;
   logic               accept;

   logic [RW:0]        nr_ext, nc_ext;
   logic               n_oor;
   logic [RW-1:0]      nr, nc;
   logic               nb_last, cell_last;
   logic [1:0]         heads_fin;

   assign req_type = req_tuser;
   assign row      = req_tdata[ROW_W-1:0];
   assign col      = req_tdata[ROW_W+COL_W-1:ROW_W];
   assign cell_in  = req_tdata[ROW_W+COL_W+CELL_W-1:ROW_W+COL_W];

   assign in_grid = (CMPW'(row) < CMPW'(GRID_SIZE)) && (CMPW'(col) < CMPW'(GRID_SIZE));
   assign req_r   = RW'(CMPW'(row));
   assign req_c   = RW'(CMPW'(col));

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DW-CELL_W-1){1'b0}}, 1'b1, rsp_cell_ff};

   // neighbour coordinates, offset by one so that -1 shows as zero
   assign nr_ext = (RW+1)'(cell_r_ff) + (RW+1)'(dr_ff);
   assign nc_ext = (RW+1)'(cell_c_ff) + (RW+1)'(dc_ff);
   assign n_oor  = (nr_ext == '0) || (nr_ext > (RW+1)'(GRID_SIZE)) ||
                   (nc_ext == '0) || (nc_ext > (RW+1)'(GRID_SIZE));
   assign nr     = RW'(nr_ext - (RW+1)'(1));
   assign nc     = RW'(nc_ext - (RW+1)'(1));

   assign nb_last   = (dr_ff == 2'd2) && (dc_ff == 2'd2);
   assign cell_last = (cell_r_ff == RW'(GRID_SIZE - 1)) && (cell_c_ff == RW'(GRID_SIZE - 1));

   assign rd_cell   = cur_ff ? rd1_ff : rd0_ff;
   assign heads_fin = heads_add(heads_ff, pend_ff && !pend_oor_ff && !pend_ctr_ff &&
                                          rd_cell == CELL_HEAD);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      clr_in       = clr_ff;
      cell_r_in    = cell_r_ff;
      cell_c_in    = cell_c_ff;
      dr_in        = dr_ff;
      dc_in        = dc_ff;
      pend_in      = 1'b0;
      pend_oor_in  = n_oor;
      pend_ctr_in  = (dr_ff == 2'd1) && (dc_ff == 2'd1);
      heads_in     = heads_ff;
      center_in    = center_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_cell_in  = rsp_cell_ff;
      rd_addr      = {req_r, req_c};
      wr_en        = 1'b0;
      wr_bank      = cur_ff;
      wr_addr      = {req_r, req_c};
      wr_data      = cell_in;

      // word in flight from the previous neighbour read
      if (pend_ff) begin
         if (pend_ctr_ff) begin
            center_in = rd_cell;
         end else begin
            heads_in = heads_fin;
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_bank = 1'b0;
            wr_addr = clr_ff;
            wr_data = CELL_EMPTY;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_WRITE: begin
                     wr_en        = in_grid;
                     rsp_valid_in = 1'b1;
                     rsp_cell_in  = CELL_EMPTY;
                  end
                  REQ_READ: begin
                     if (in_grid) begin
                        state_in = ST_RD_WAIT;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_cell_in  = CELL_EMPTY;
                     end
                  end
                  REQ_STEP: begin
                     state_in  = ST_STEP_RD;
                     cell_r_in = '0;
                     cell_c_in = '0;
                     dr_in     = 2'd0;
                     dc_in     = 2'd0;
                     heads_in  = 2'd0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_cell_in  = CELL_EMPTY;
                  end
               endcase
            end
         end
         ST_RD_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_cell_in  = rd_cell;
            state_in     = ST_IDLE;
         end
         ST_STEP_RD: begin
            rd_addr = {nr, nc};
            pend_in = 1'b1;
            if (dc_ff == 2'd2) begin
               dc_in = 2'd0;
               dr_in = dr_ff + 2'd1;
            end else begin
               dc_in = dc_ff + 2'd1;
            end
            if (nb_last) begin
               dr_in    = 2'd0;
               state_in = ST_STEP_FIN;
            end
         end
         ST_STEP_FIN: begin
            wr_en    = 1'b1;
            wr_bank  = !cur_ff;
            wr_addr  = {cell_r_ff, cell_c_ff};
            wr_data  = cell_evolve(center_ff, heads_fin);
            heads_in = 2'd0;
            if (cell_c_ff == RW'(GRID_SIZE - 1)) begin
               cell_c_in = '0;
               cell_r_in = cell_r_ff + RW'(1);
            end else begin
               cell_c_in = cell_c_ff + RW'(1);
            end
            if (cell_last) begin
               cur_in       = !cur_ff;
               rsp_valid_in = 1'b1;
               rsp_cell_in  = CELL_EMPTY;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_STEP_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cur_ff       <= 1'b0;
         clr_ff       <= '0;
         dr_ff        <= 2'd0;
         dc_ff        <= 2'd0;
         pend_ff      <= 1'b0;
         heads_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         clr_ff       <= clr_in;
         dr_ff        <= dr_in;
         dc_ff        <= dc_in;
         pend_ff      <= pend_in;
         heads_ff     <= heads_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cell_r_ff   <= cell_r_in;
      cell_c_ff   <= cell_c_in;
      pend_oor_ff <= pend_oor_in;
      pend_ctr_ff <= pend_ctr_in;
      center_ff   <= center_in;
      rsp_cell_ff <= rsp_cell_in;
   end

   // grid banks: one write and one registered read each
   always_ff @(posedge clock) begin
      if (wr_en && !wr_bank) begin
         mem0[wr_addr] <= wr_data;
      end
      rd0_ff <= mem0[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr_bank) begin
         mem1[wr_addr] <= wr_data;
      end
      rd1_ff <= mem1[rd_addr];
   end

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_tready)
      else $error("request taken during clearing pass");

   a_offsets_in_range: assert property (@(posedge clock) disable iff (reset)
      dr_ff != 2'd3 && dc_ff != 2'd3)
      else $error("neighbour offset out of range");

   a_bank_swap: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STEP_FIN && cell_last |=> cur_ff != $past(cur_ff))
      else $error("banks not swapped at end of generation");

   a_step_answers: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STEP_FIN && cell_last |=> rsp_tvalid && rsp_tdata[1:0] == CELL_EMPTY)
      else $error("generation step gave no response");

endmodule
